[sv/phtds_pkg.sv]
// Shared types and constants for the pH and TDS probe conversion block.
package phtds_pkg;

  localparam int ADC_BITS  = 12;
  localparam int FRAC_BITS = 16;

  localparam int FUNC_W    = 2;
  localparam int TEMP_W    = 11;
  localparam int KNOWN_W   = 20;
  localparam int PH_OUT_W  = 13;
  localparam int TDS_OUT_W = 23;
  localparam int STATUS_W  = 2;

  localparam int PH_COR_W  = 13;
  localparam int TDS_COR_W = 22;

  localparam int MUL_A_W   = 25;
  localparam int MUL_B_W   = 19;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam int DIV_W     = 34;
  localparam int DVS_W     = 21;
  localparam int STEP_W    = 5;

  localparam int V_W       = 18;
  localparam int PHR_W     = 12;
  localparam int COEF_W    = 18;
  localparam int CV_W      = 19;
  localparam int CV2_W     = 22;
  localparam int CV3_W     = 25;
  localparam int ACC_W     = 41;
  localparam int TDR_W     = 24;

  localparam logic [TEMP_W-1:0] TEMP_MAX  = 11'd1600;
  localparam logic [TEMP_W-1:0] TEMP_BIAS = 11'd400;

  // voltage = round(code * 3.3 * 2^FRAC_BITS / 2^ADC_BITS) = round(code * 264 / 5)
  localparam logic [MUL_B_W-1:0] VOLT_MUL = 19'd264;
  localparam logic [DVS_W-1:0]   VOLT_DIV = 21'd5;
  localparam logic [21:0]        VOLT_RND = 22'd2;

  // pH numerator = 700*18*ONE + 2.5*ONE*10000 - v*10000, plus half the divisor
  localparam logic [MUL_B_W-1:0] PH_MUL  = 19'd10000;
  localparam logic [31:0]        PH_BASE = 32'd2464743424;
  localparam logic [DVS_W-1:0]   PH_DIV  = 21'd1179648;

  localparam logic [DVS_W-1:0]   COEF_DIV = 21'd800;
  localparam logic [27:0]        COEF_RND = 28'd400;

  localparam logic [MUL_B_W-1:0] TDS_C3 = 19'd13342;
  localparam logic [MUL_B_W-1:0] TDS_C2 = 19'd25586;
  localparam logic [MUL_B_W-1:0] TDS_C1 = 19'd85739;

  localparam logic [STEP_W-1:0] STEPS_VOLT = 5'd11;
  localparam logic [STEP_W-1:0] STEPS_PH   = 5'd16;
  localparam logic [STEP_W-1:0] STEPS_COEF = 5'd14;
  localparam logic [STEP_W-1:0] STEPS_CV   = 5'd17;

  localparam logic [STATUS_W-1:0] STATUS_MEASURED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PH_CAL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TDS_CAL  = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MEASURE = 2'd0,
    FUNC_CAL_PH  = 2'd1,
    FUNC_CAL_TDS = 2'd2
  } func_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_VPH_M,
    S_VPH_D0,
    S_VPH_DW,
    S_PH_M,
    S_PH_D0,
    S_PH_DW,
    S_VTD_M,
    S_VTD_D0,
    S_VTD_DW,
    S_COEF_D0,
    S_COEF_DW,
    S_CV_D0,
    S_CV_DW,
    S_CV2_M,
    S_CV2_R,
    S_CV3_M,
    S_CV3_R,
    S_T3_M,
    S_T2_M,
    S_T1_M,
    S_T1_A,
    S_RND,
    S_OFS,
    S_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

endpackage

[sv/phtds_div.sv]
// Restoring unsigned divider, two quotient bits per cycle, left-aligned dividend.
module phtds_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  phtds_pkg::div_req_t          req_i,
  output logic                         done_o,
  output logic [phtds_pkg::DIV_W-1:0]  quo_o
);
  import phtds_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  dvs_q;

  logic [DVS_W:0]    r1, r2;
  logic [DVS_W-1:0]  r1n, r2n;
  logic              ge1, ge2;

  always_comb begin
    r1  = {rem_q, quo_q[DIV_W-1]};
    ge1 = r1 >= {1'b0, dvs_q};
    r1n = ge1 ? DVS_W'(r1 - {1'b0, dvs_q}) : r1[DVS_W-1:0];
    r2  = {r1n, quo_q[DIV_W-2]};
    ge2 = r2 >= {1'b0, dvs_q};
    r2n = ge2 ? DVS_W'(r2 - {1'b0, dvs_q}) : r2[DVS_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = '0;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      cnt_d = cnt_q - STEP_W'(1);
      rem_d = r2n;
      quo_d = {quo_q[DIV_W-3:0], ge1, ge2};
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[sv/ph_tds_sensor_calibrated_conversion_top.sv]
// Top level of the pH and TDS probe conversion block with offset calibration.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o   func, raw_ph_code, raw_tds_code,
//                                               temp_code, ref_level
//   out      source     out_valid_o / out_stall_i ph_value, tds_value, status, saturated
//
// Each request makes five passes of the shared two-bit-per-cycle divider
// and eight passes of the shared multiplier.
// in_stall_o is low only in the idle state; one request is in work at a time.
// A finished result waits in the output register while the next request is taken.
// Reset clears both offsets, the sequencer and out_valid_o.
module ph_tds_sensor_calibrated_conversion_top (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [phtds_pkg::FUNC_W-1:0]             func_i,
  input  logic [phtds_pkg::ADC_BITS-1:0]           raw_ph_code_i,
  input  logic [phtds_pkg::ADC_BITS-1:0]           raw_tds_code_i,
  input  logic [phtds_pkg::TEMP_W-1:0]             temp_code_i,
  input  logic [phtds_pkg::KNOWN_W-1:0]            ref_level_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [phtds_pkg::PH_OUT_W-1:0]    ph_value_o,
  output logic signed [phtds_pkg::TDS_OUT_W-1:0]   tds_value_o,
  output logic [phtds_pkg::STATUS_W-1:0]           status_o,
  output logic                                     saturated_o
);
  import phtds_pkg::*;

  state_e state_q, state_d;

  logic [FUNC_W-1:0]    func_q;
  logic [ADC_BITS-1:0]  ph_code_q;
  logic [ADC_BITS-1:0]  tds_code_q;
  logic [TEMP_W-1:0]    temp_q;
  logic [KNOWN_W-1:0]   known_q;
  logic [V_W-1:0]       v_q;
  logic [PHR_W-1:0]     ph_raw_q;
  logic [COEF_W-1:0]    coef_q;
  logic [CV_W-1:0]      cv_q;
  logic [CV2_W-1:0]     cv2_q;
  logic [CV3_W-1:0]     cv3_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [TDR_W-1:0] tds_raw_q;
  logic                 sat_q;

  logic signed [PH_COR_W-1:0]  ph_corr_q;
  logic signed [TDS_COR_W-1:0] tds_corr_q;

  logic                        out_valid_q;
  logic signed [PH_OUT_W-1:0]  ph_out_q;
  logic signed [TDS_OUT_W-1:0] tds_out_q;
  logic [STATUS_W-1:0]         status_q;
  logic                        sat_out_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_q;
  logic [PROD_W-1:0]  prod_rnd;

  div_req_t          div_req;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;

  logic              in_accept;
  logic              out_fire;

  logic [TEMP_W-1:0] temp_sum;
  logic [27:0]       coef_num;
  logic signed [ACC_W-1:0] acc_bias;
  logic signed [ACC_W-1:0] acc_rnd;

  logic signed [21:0] ph_diff;
  logic signed [24:0] tds_diff;
  logic signed [PH_COR_W-1:0]  ph_ofs;
  logic signed [TDS_COR_W-1:0] tds_ofs;
  logic               ph_ofs_sat, tds_ofs_sat;

  logic signed [13:0] ph_sum;
  logic signed [24:0] tds_sum;
  logic signed [PH_OUT_W-1:0]  ph_clip;
  logic signed [TDS_OUT_W-1:0] tds_clip;
  logic               ph_out_sat, tds_out_sat;
  logic [STATUS_W-1:0] status_d;

  phtds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_fire  = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_accept) state_d = S_VPH_M;
      S_VPH_M:   state_d = S_VPH_D0;
      S_VPH_D0:  state_d = S_VPH_DW;
      S_VPH_DW:  if (div_done) state_d = S_PH_M;
      S_PH_M:    state_d = S_PH_D0;
      S_PH_D0:   state_d = S_PH_DW;
      S_PH_DW:   if (div_done) state_d = S_VTD_M;
      S_VTD_M:   state_d = S_VTD_D0;
      S_VTD_D0:  state_d = S_VTD_DW;
      S_VTD_DW:  if (div_done) state_d = S_COEF_D0;
      S_COEF_D0: state_d = S_COEF_DW;
      S_COEF_DW: if (div_done) state_d = S_CV_D0;
      S_CV_D0:   state_d = S_CV_DW;
      S_CV_DW:   if (div_done) state_d = S_CV2_M;
      S_CV2_M:   state_d = S_CV2_R;
      S_CV2_R:   state_d = S_CV3_M;
      S_CV3_M:   state_d = S_CV3_R;
      S_CV3_R:   state_d = S_T3_M;
      S_T3_M:    state_d = S_T2_M;
      S_T2_M:    state_d = S_T1_M;
      S_T1_M:    state_d = S_T1_A;
      S_T1_A:    state_d = S_RND;
      S_RND:     state_d = S_OFS;
      S_OFS:     state_d = S_OUT;
      S_OUT:     if (out_fire) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // shared multiplier operands, divider requests, input stall
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    mul_a      = '0;
    mul_b      = '0;
    div_req    = '0;
    temp_sum   = TEMP_BIAS + temp_q;
    coef_num   = 28'({temp_sum, {FRAC_BITS{1'b0}}}) + COEF_RND;
    case (state_q)
      S_VPH_M: begin
        mul_a = MUL_A_W'(ph_code_q);
        mul_b = VOLT_MUL;
      end
      S_VPH_D0, S_VTD_D0: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_VOLT;
        div_req.dividend = {mul_q[21:0] + VOLT_RND, 12'b0};
        div_req.divisor  = VOLT_DIV;
      end
      S_PH_M: begin
        mul_a = MUL_A_W'(v_q);
        mul_b = PH_MUL;
      end
      S_PH_D0: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_PH;
        div_req.dividend = {PH_BASE - mul_q[31:0], 2'b0};
        div_req.divisor  = PH_DIV;
      end
      S_VTD_M: begin
        mul_a = MUL_A_W'(tds_code_q);
        mul_b = VOLT_MUL;
      end
      S_COEF_D0: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_COEF;
        div_req.dividend = {coef_num, 6'b0};
        div_req.divisor  = COEF_DIV;
      end
      S_CV_D0: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_CV;
        div_req.dividend = DIV_W'({v_q, {FRAC_BITS{1'b0}}})
                         + DIV_W'(coef_q[COEF_W-1:1]);
        div_req.divisor  = DVS_W'(coef_q);
      end
      S_CV2_M: begin
        mul_a = MUL_A_W'(cv_q);
        mul_b = cv_q;
      end
      S_CV3_M: begin
        mul_a = MUL_A_W'(cv2_q);
        mul_b = cv_q;
      end
      S_T3_M: begin
        mul_a = cv3_q;
        mul_b = TDS_C3;
      end
      S_T2_M: begin
        mul_a = MUL_A_W'(cv2_q);
        mul_b = TDS_C2;
      end
      S_T1_M: begin
        mul_a = MUL_A_W'(cv_q);
        mul_b = TDS_C1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // rounding, offset and output clipping
  always_comb begin
    prod_rnd = mul_q + (PROD_W'(1) << (FRAC_BITS - 1));
    acc_bias = acc_q[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : ACC_W'(1 << FRAC_BITS);
    acc_rnd  = (acc_q + acc_bias) >>> (FRAC_BITS + 1);

    ph_diff  = $signed({2'b00, known_q}) - $signed({10'b0, ph_raw_q});
    tds_diff = $signed({5'b0, known_q}) - $signed({tds_raw_q[TDR_W-1], tds_raw_q});

    ph_ofs_sat = 1'b1;
    if (ph_diff < -22'sd4096) begin
      ph_ofs = $signed(13'h1000);
    end else if (ph_diff > 22'sd4095) begin
      ph_ofs = 13'sd4095;
    end else begin
      ph_ofs     = ph_diff[PH_COR_W-1:0];
      ph_ofs_sat = 1'b0;
    end

    tds_ofs_sat = 1'b1;
    if (tds_diff < -25'sd2097152) begin
      tds_ofs = $signed(22'h200000);
    end else if (tds_diff > 25'sd2097151) begin
      tds_ofs = 22'sd2097151;
    end else begin
      tds_ofs     = tds_diff[TDS_COR_W-1:0];
      tds_ofs_sat = 1'b0;
    end

    ph_sum  = $signed({2'b00, ph_raw_q}) + $signed({ph_corr_q[PH_COR_W-1], ph_corr_q});
    tds_sum = $signed({tds_raw_q[TDR_W-1], tds_raw_q})
            + $signed({{3{tds_corr_q[TDS_COR_W-1]}}, tds_corr_q});

    ph_out_sat = 1'b1;
    if (ph_sum < -14'sd4000) begin
      ph_clip = -13'sd4000;
    end else if (ph_sum > 14'sd4000) begin
      ph_clip = 13'sd4000;
    end else begin
      ph_clip    = ph_sum[PH_OUT_W-1:0];
      ph_out_sat = 1'b0;
    end

    tds_out_sat = 1'b1;
    if (tds_sum < -25'sd2000000) begin
      tds_clip = -23'sd2000000;
    end else if (tds_sum > 25'sd3000000) begin
      tds_clip = 23'sd3000000;
    end else begin
      tds_clip    = tds_sum[TDS_OUT_W-1:0];
      tds_out_sat = 1'b0;
    end

    case (func_q)
      FUNC_CAL_PH:  status_d = STATUS_PH_CAL;
      FUNC_CAL_TDS: status_d = STATUS_TDS_CAL;
      default:      status_d = STATUS_MEASURED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_corr_q   <= '0;
      tds_corr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OFS) begin
        if (func_q == FUNC_CAL_PH) begin
          ph_corr_q <= ph_ofs;
        end
        if (func_q == FUNC_CAL_TDS) begin
          tds_corr_q <= tds_ofs;
        end
      end
      if (out_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          func_q     <= func_i;
          ph_code_q  <= raw_ph_code_i;
          tds_code_q <= raw_tds_code_i;
          temp_q     <= (temp_code_i > TEMP_MAX) ? TEMP_MAX : temp_code_i;
          known_q    <= ref_level_i;
        end
      end
      S_VPH_DW, S_VTD_DW: if (div_done) v_q <= div_quo[V_W-1:0];
      S_PH_DW:   if (div_done) ph_raw_q <= div_quo[PHR_W-1:0];
      S_COEF_DW: if (div_done) coef_q <= div_quo[COEF_W-1:0];
      S_CV_DW:   if (div_done) cv_q <= div_quo[CV_W-1:0];
      S_CV2_R:   cv2_q <= prod_rnd[FRAC_BITS +: CV2_W];
      S_CV3_R:   cv3_q <= prod_rnd[FRAC_BITS +: CV3_W];
      S_T2_M:    acc_q <= $signed({1'b0, mul_q[ACC_W-2:0]});
      S_T1_M:    acc_q <= acc_q - $signed({1'b0, mul_q[ACC_W-2:0]});
      S_T1_A:    acc_q <= acc_q + $signed({1'b0, mul_q[ACC_W-2:0]});
      S_RND:     tds_raw_q <= acc_rnd[TDR_W-1:0];
      S_OFS: begin
        case (func_q)
          FUNC_CAL_PH:  sat_q <= ph_ofs_sat;
          FUNC_CAL_TDS: sat_q <= tds_ofs_sat;
          default:      sat_q <= 1'b0;
        endcase
      end
      S_OUT: begin
        if (out_fire) begin
          ph_out_q  <= ph_clip;
          tds_out_q <= tds_clip;
          status_q  <= status_d;
          sat_out_q <= sat_q | ph_out_sat | tds_out_sat;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign ph_value_o  = ph_out_q;
  assign tds_value_o = tds_out_q;
  assign status_o    = status_q;
  assign saturated_o = sat_out_q;

endmodule
